// File: hw/rtl/mbrc_pkg.sv
// Shared types, constants and the CRC byte update for the Modbus RTU reply checker.
package mbrc_pkg;

  localparam int BUFFER_BYTES = 256;
  // Byte counter must hold BUFFER_BYTES itself.
  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int LEN_W = 9;
  // Compare width wide enough for count + 2 and for any target length.
  localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;
  localparam logic [6:0] FUNC_MASK = 7'h7F;

  localparam logic [1:0] FUNC_ARM = 2'd0;
  localparam logic [1:0] FUNC_BYTE = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  typedef enum logic [3:0] {
    ST_PENDING   = 4'd0,
    ST_OK        = 4'd1,
    ST_BUSY      = 4'd2,
    ST_TIMEOUT   = 4'd3,
    ST_OVERFLOW  = 4'd4,
    ST_WRONGUNIT = 4'd5,
    ST_WRONGFUNC = 4'd6,
    ST_EXCEPTION = 4'd7,
    ST_CRCFAIL   = 4'd8,
    ST_IGNORED   = 4'd9
  } status_t;

  function automatic logic [7:0] bit_reverse8(input logic [7:0] b);
    logic [7:0] v;
    v = ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
    v = ((v & 8'hCC) >> 2) | ((v & 8'h33) << 2);
    v = {v[3:0], v[7:4]};
    return v;
  endfunction

  // One byte into the CRC, reflected input, MSB-first shift.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {bit_reverse8(b), 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/mbrc_chan_if.sv
// Valid/ready channel interfaces for the item, result and configuration transfers.
interface mbrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;
  logic [7:0] unit_address;
  logic [6:0] function_code;
  logic [8:0] fixed_length;

  modport source (output valid, func, rx_byte, unit_address, function_code, fixed_length,
                  input ready);
  modport sink (input valid, func, rx_byte, unit_address, function_code, fixed_length,
                output ready);
endinterface

interface mbrc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic       done_res;
  logic [7:0] exception_code;

  modport source (output valid, status, done_res, exception_code, input ready);
  modport sink (input valid, status, done_res, exception_code, output ready);
endinterface

interface mbrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;

  modport source (output valid, timeout_ticks, input ready);
  modport sink (input valid, timeout_ticks, output ready);
endinterface

// File: hw/rtl/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU reply checker: input register, check logic, result register.
//
// Usage: an arm item (func 0) loads the expected unit, function code and reply
// length and opens a pending reply; arm items while a reply is pending return
// busy. Byte items (func 1) feed the reply, tick items (func 2) count time.
// Every item yields exactly one result transfer carrying status, done_res and
// exception_code. The CRC of each byte is updated in the same cycle it is
// checked, so the frame verdict comes with the last byte.
// An item passes the input register, then the result register, which drives out_if.
// Throughput: one item per cycle while the result channel keeps up; when the receiver
// stalls, the result register holds and the input register fills, after which
// in_if.ready drops until the stall clears.
// The timeout limit is written on the cfg channel, which is always ready and
// must only be written while no item is in flight.
// Reset (rst_n low, synchronous) empties both registers, closes any pending
// reply and restores a timeout limit of 5000 ticks.
module modbus_rtu_response_checker (
  input  logic              clk,
  input  logic              rst_n,
  mbrc_in_if.sink           in_if,
  mbrc_out_if.source        out_if,
  mbrc_cfg_if.sink          cfg_if
);

  localparam int CNT_W = mbrc_pkg::CNT_W;
  localparam int LEN_W = mbrc_pkg::LEN_W;
  localparam int CMP_W = mbrc_pkg::CMP_W;

  // Input register.
  logic       s1_valid_r;
  logic [1:0] s1_func_r;
  logic [7:0] s1_byte_r;
  logic [7:0] s1_unit_r;
  logic [6:0] s1_code_r;
  logic [8:0] s1_len_r;

  // Result register.
  logic                  out_valid_r;
  mbrc_pkg::status_t     out_status_r, out_status_nxt;
  logic                  out_done_r, out_done_nxt;
  logic [7:0]            out_exc_r, out_exc_nxt;

  logic [15:0] timeout_r;

  // Reply state.
  logic              receiving_r, receiving_nxt;
  logic [7:0]        exp_unit_r, exp_unit_nxt;
  logic [6:0]        exp_func_r, exp_func_nxt;
  logic [LEN_W-1:0]  tlen_r, tlen_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [15:0]       ticks_r, ticks_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        crc_hi_r, crc_hi_nxt;
  logic              exc_flag_r, exc_flag_nxt;
  logic [7:0]        saved_r, saved_nxt;

  logic out_free;
  logic proc;

  // Byte path helpers.
  logic [CMP_W-1:0] n_ext;
  logic [CMP_W-1:0] nb_ext;
  logic [CMP_W-1:0] tlen_ext;
  logic [LEN_W-1:0] arm_len;
  logic [15:0]      tick_inc;

  assign out_free = !out_valid_r || out_if.ready;
  assign proc = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid = out_valid_r;
  assign out_if.status = out_status_r;
  assign out_if.done_res = out_done_r;
  assign out_if.exception_code = out_exc_r;

  assign n_ext = CMP_W'(seen_r);
  assign nb_ext = CMP_W'(seen_r) + CMP_W'(1);
  assign tick_inc = (ticks_r < mbrc_pkg::TICKS_MAX) ? ticks_r + 16'd1 : ticks_r;

  // Fixed lengths of one to three bytes are treated as four.
  always_comb begin
    arm_len = s1_len_r;
    if (s1_len_r != '0 && s1_len_r < LEN_W'(4)) begin
      arm_len = LEN_W'(4);
    end
  end

  always_comb begin
    receiving_nxt = receiving_r;
    exp_unit_nxt = exp_unit_r;
    exp_func_nxt = exp_func_r;
    tlen_nxt = tlen_r;
    seen_nxt = seen_r;
    ticks_nxt = ticks_r;
    crc_nxt = crc_r;
    crc_hi_nxt = crc_hi_r;
    exc_flag_nxt = exc_flag_r;
    saved_nxt = saved_r;
    out_status_nxt = mbrc_pkg::ST_IGNORED;
    out_done_nxt = 1'b0;
    tlen_ext = CMP_W'(tlen_r);

    unique case (s1_func_r)
      mbrc_pkg::FUNC_ARM: begin
        if (receiving_r) begin
          out_status_nxt = mbrc_pkg::ST_BUSY;
        end else begin
          exp_unit_nxt = s1_unit_r;
          exp_func_nxt = s1_code_r;
          tlen_nxt = arm_len;
          seen_nxt = '0;
          ticks_nxt = '0;
          crc_nxt = mbrc_pkg::CRC_INIT;
          crc_hi_nxt = '0;
          exc_flag_nxt = 1'b0;
          saved_nxt = '0;
          receiving_nxt = 1'b1;
          out_status_nxt = mbrc_pkg::ST_PENDING;
        end
      end
      mbrc_pkg::FUNC_BYTE: begin
        if (receiving_r) begin
          out_status_nxt = mbrc_pkg::ST_PENDING;
          if (ticks_r > timeout_r) begin
            out_status_nxt = mbrc_pkg::ST_TIMEOUT;
          end else if (n_ext >= CMP_W'(mbrc_pkg::BUFFER_BYTES)) begin
            out_status_nxt = mbrc_pkg::ST_OVERFLOW;
          end else begin
            seen_nxt = CNT_W'(nb_ext);
            // The first byte is kept for the unit check, the third is the
            // byte count or exception code.
            if (n_ext == CMP_W'(2)) begin
              saved_nxt = s1_byte_r;
              if (tlen_r == '0) begin
                tlen_nxt = LEN_W'(s1_byte_r) + LEN_W'(5);
              end
            end else if (n_ext == '0) begin
              saved_nxt = s1_byte_r;
            end
            tlen_ext = CMP_W'(tlen_nxt);

            if (tlen_nxt == '0 || (n_ext + CMP_W'(2)) < tlen_ext) begin
              crc_nxt = mbrc_pkg::crc_feed(crc_r, s1_byte_r);
            end else if ((n_ext + CMP_W'(2)) == tlen_ext) begin
              crc_hi_nxt = s1_byte_r;
            end

            if (n_ext == CMP_W'(1) && saved_r != exp_unit_r) begin
              out_status_nxt = mbrc_pkg::ST_WRONGUNIT;
            end else if (n_ext == CMP_W'(1) &&
                         (s1_byte_r[6:0] & mbrc_pkg::FUNC_MASK) != exp_func_r) begin
              out_status_nxt = mbrc_pkg::ST_WRONGFUNC;
            end else begin
              if (n_ext == CMP_W'(1)) begin
                exc_flag_nxt = s1_byte_r[7];
              end
              if (nb_ext >= CMP_W'(2)) begin
                if (nb_ext >= CMP_W'(5) && exc_flag_nxt) begin
                  out_status_nxt = mbrc_pkg::ST_EXCEPTION;
                end else if (tlen_nxt != '0 && nb_ext >= tlen_ext) begin
                  if ({crc_hi_nxt, s1_byte_r} == crc_nxt) begin
                    out_status_nxt = mbrc_pkg::ST_OK;
                  end else begin
                    out_status_nxt = mbrc_pkg::ST_CRCFAIL;
                  end
                end
              end
            end
          end
          if (out_status_nxt != mbrc_pkg::ST_PENDING) begin
            receiving_nxt = 1'b0;
            out_done_nxt = 1'b1;
          end
        end
      end
      mbrc_pkg::FUNC_TICK: begin
        if (receiving_r) begin
          ticks_nxt = tick_inc;
          if (tick_inc > timeout_r) begin
            out_status_nxt = mbrc_pkg::ST_TIMEOUT;
            out_done_nxt = 1'b1;
            receiving_nxt = 1'b0;
          end else begin
            out_status_nxt = mbrc_pkg::ST_PENDING;
          end
        end
      end
      default: begin
        out_status_nxt = mbrc_pkg::ST_IGNORED;
      end
    endcase

    out_exc_nxt = (out_status_nxt == mbrc_pkg::ST_EXCEPTION) ? saved_nxt : 8'h00;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      receiving_r <= 1'b0;
      timeout_r <= mbrc_pkg::TIMEOUT_RESET;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (proc) begin
        receiving_r <= receiving_nxt;
      end
      if (cfg_if.valid) begin
        timeout_r <= cfg_if.timeout_ticks;
      end
    end
  end

  // Payload and per-reply state; every per-reply field is loaded on arm before use.
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_func_r <= in_if.func;
      s1_byte_r <= in_if.rx_byte;
      s1_unit_r <= in_if.unit_address;
      s1_code_r <= in_if.function_code;
      s1_len_r <= in_if.fixed_length;
    end
    if (proc) begin
      out_status_r <= out_status_nxt;
      out_done_r <= out_done_nxt;
      out_exc_r <= out_exc_nxt;
      exp_unit_r <= exp_unit_nxt;
      exp_func_r <= exp_func_nxt;
      tlen_r <= tlen_nxt;
      seen_r <= seen_nxt;
      ticks_r <= ticks_nxt;
      crc_r <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
      exc_flag_r <= exc_flag_nxt;
      saved_r <= saved_nxt;
    end
  end

  // A result that ends a reply carries a final verdict.
  a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |->
      out_status_r != mbrc_pkg::ST_PENDING && out_status_r != mbrc_pkg::ST_BUSY &&
      out_status_r != mbrc_pkg::ST_IGNORED)
    else $error("done_res set without a final status");

  // The exception code is only reported with an exception status.
  a_exc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_exc_r != 8'h00 |-> out_status_r == mbrc_pkg::ST_EXCEPTION)
    else $error("exception code outside an exception result");

  // An accepted arm while idle opens a reply.
  a_arm_opens: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_func_r == mbrc_pkg::FUNC_ARM && !receiving_r |=> receiving_r)
    else $error("arm did not open a reply");

  // The byte counter never passes the buffer size while a reply is open.
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    receiving_r |-> CMP_W'(seen_r) <= CMP_W'(mbrc_pkg::BUFFER_BYTES))
    else $error("byte count beyond buffer size");

  // A reply only closes together with a result that says so.
  a_close_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(receiving_r) |-> out_valid_r && out_done_r)
    else $error("reply closed without a done result");

endmodule

// File: bench/mbrc_verdict_checker.sv
// Checker for the Modbus RTU reply checker: predicts each result and compares the result transfers.
module mbrc_verdict_checker (
  input  logic clk,
  input  logic rst_n,
  mbrc_in_if   in_if,
  mbrc_out_if  out_if,
  mbrc_cfg_if  cfg_if,
  output int   mismatches,
  output int   awaiting
);

  typedef struct packed {
    mbrc_pkg::status_t status;
    logic              done;
    logic [7:0]        code;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [15:0] timeout_lim;
  logic        rx_active;
  logic [7:0]  exp_unit;
  logic [6:0]  exp_func;
  int          tgt_len;
  int          nbytes;
  logic [15:0] ticks;
  logic [15:0] crc;
  logic [7:0]  crc_hi;
  logic        exc_flag;
  logic [7:0]  saved;
  int          fail_cnt = 0;
  int          depth = 0;

  assign mismatches = fail_cnt;
  assign awaiting = depth;

  // Bitwise form of the reflected-input CRC: data bits enter LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[15] ^ data[k];
      r = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ mbrc_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic mbrc_pkg::status_t absorb_byte(input logic [7:0] data);
    mbrc_pkg::status_t st;
    int                n;
    st = mbrc_pkg::ST_PENDING;
    if (ticks > timeout_lim) begin
      st = mbrc_pkg::ST_TIMEOUT;
    end else if (nbytes >= mbrc_pkg::BUFFER_BYTES) begin
      st = mbrc_pkg::ST_OVERFLOW;
    end else begin
      n = nbytes;
      nbytes = n + 1;
      // The first byte is parked where the third byte later goes.
      if (n == 2) begin
        saved = data;
        if (tgt_len == 0) begin
          tgt_len = int'(data) + 5;
        end
      end else if (n == 0) begin
        saved = data;
      end
      if (tgt_len == 0 || n + 2 < tgt_len) begin
        crc = crc_byte(crc, data);
      end else if (n + 2 == tgt_len) begin
        crc_hi = data;
      end
      if (n == 1 && saved != exp_unit) begin
        st = mbrc_pkg::ST_WRONGUNIT;
      end else if (n == 1 && data[6:0] != exp_func) begin
        st = mbrc_pkg::ST_WRONGFUNC;
      end else begin
        if (n == 1) begin
          exc_flag = data[7];
        end
        if (nbytes >= 5 && exc_flag) begin
          st = mbrc_pkg::ST_EXCEPTION;
        end else if (nbytes >= 2 && tgt_len != 0 && nbytes >= tgt_len) begin
          st = ({crc_hi, data} == crc) ? mbrc_pkg::ST_OK : mbrc_pkg::ST_CRCFAIL;
        end
      end
    end
    if (st != mbrc_pkg::ST_PENDING) begin
      rx_active = 1'b0;
    end
    return st;
  endfunction

  function automatic verdict_t predict_verdict(input logic [1:0] f, input logic [7:0] data,
                                               input logic [7:0] ua, input logic [6:0] fc,
                                               input logic [8:0] fl);
    verdict_t v;
    v.status = mbrc_pkg::ST_IGNORED;
    v.done = 1'b0;
    v.code = 8'h00;
    case (f)
      mbrc_pkg::FUNC_ARM: begin
        if (rx_active) begin
          v.status = mbrc_pkg::ST_BUSY;
        end else begin
          exp_unit = ua;
          exp_func = fc;
          tgt_len = (fl != 0 && fl < 4) ? 4 : int'(fl);
          nbytes = 0;
          ticks = 16'h0000;
          crc = mbrc_pkg::CRC_INIT;
          crc_hi = 8'h00;
          exc_flag = 1'b0;
          saved = 8'h00;
          rx_active = 1'b1;
          v.status = mbrc_pkg::ST_PENDING;
        end
      end
      mbrc_pkg::FUNC_BYTE: begin
        if (rx_active) begin
          v.status = absorb_byte(data);
          v.done = !rx_active;
        end
      end
      mbrc_pkg::FUNC_TICK: begin
        if (rx_active) begin
          if (ticks != mbrc_pkg::TICKS_MAX) begin
            ticks = ticks + 16'd1;
          end
          if (ticks > timeout_lim) begin
            rx_active = 1'b0;
            v.status = mbrc_pkg::ST_TIMEOUT;
            v.done = 1'b1;
          end else begin
            v.status = mbrc_pkg::ST_PENDING;
          end
        end
      end
      default: begin
      end
    endcase
    if (v.status == mbrc_pkg::ST_EXCEPTION) begin
      v.code = saved;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      timeout_lim = mbrc_pkg::TIMEOUT_RESET;
      rx_active = 1'b0;
      exp_unit = 8'h00;
      exp_func = 7'h00;
      tgt_len = 0;
      nbytes = 0;
      ticks = 16'h0000;
      crc = mbrc_pkg::CRC_INIT;
      crc_hi = 8'h00;
      exc_flag = 1'b0;
      saved = 8'h00;
      verdict_q.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        timeout_lim = cfg_if.timeout_ticks;
      end
      if (in_if.valid && in_if.ready) begin
        verdict_q.push_back(predict_verdict(in_if.func, in_if.rx_byte, in_if.unit_address,
                                            in_if.function_code, in_if.fixed_length));
      end
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result transfer with nothing expected, status %0d", $time,
                   out_if.status);
        end else begin
          want = verdict_q.pop_front();
          if (out_if.status !== want.status) begin
            fail_cnt++;
            $display("%0t: status expected %0d got %0d", $time, want.status, out_if.status);
          end
          if (out_if.done_res !== want.done) begin
            fail_cnt++;
            $display("%0t: done_res expected %0d got %0d", $time, want.done, out_if.done_res);
          end
          if (out_if.exception_code !== want.code) begin
            fail_cnt++;
            $display("%0t: exception_code expected %0h got %0h", $time, want.code,
                     out_if.exception_code);
          end
        end
      end
    end
    depth = verdict_q.size();
  end

endmodule

// File: bench/modbus_rtu_response_checker_tb.sv
// Top of the Modbus RTU reply checker testbench: clock, reset, reply stimulus and the verdict.
module modbus_rtu_response_checker_tb;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   awaiting;
  int   sent = 0;
  int   hold_requests = 0;
  bit   idle_on = 1'b1;
  logic [15:0] cur_limit = mbrc_pkg::TIMEOUT_RESET;

  mbrc_in_if  in_ch ();
  mbrc_out_if out_ch ();
  mbrc_cfg_if cfg_ch ();

  modbus_rtu_response_checker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  mbrc_verdict_checker i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_if     (cfg_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #10000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin : receiver
    int served;
    served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served = hold_requests;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] f, input logic [7:0] data, input logic [7:0] ua,
                           input logic [6:0] fc, input logic [8:0] fl);
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.rx_byte <= data;
    in_ch.unit_address <= ua;
    in_ch.function_code <= fc;
    in_ch.fixed_length <= fl;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic arm(input logic [7:0] ua, input logic [6:0] fc, input logic [8:0] fl);
    send_item(mbrc_pkg::FUNC_ARM, 8'($urandom), ua, fc, fl);
  endtask

  task automatic put_byte(input logic [7:0] data);
    send_item(mbrc_pkg::FUNC_BYTE, data, 8'($urandom), 7'($urandom),
              9'($urandom_range(0, 256)));
  endtask

  task automatic tick();
    send_item(mbrc_pkg::FUNC_TICK, 8'($urandom), 8'($urandom), 7'($urandom),
              9'($urandom_range(0, 256)));
  endtask

  // Waits until every transfer has its result, with a margin for the two pipeline stages.
  task automatic drain();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] lim);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.timeout_ticks <= lim;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    cur_limit = lim;
  endtask

  function automatic byte_q_t with_crc(input byte_q_t body);
    logic [15:0] acc;
    byte_q_t     q;
    acc = mbrc_pkg::CRC_INIT;
    q = body;
    foreach (body[i]) acc = i_check.crc_byte(acc, body[i]);
    q.push_back(acc[15:8]);
    q.push_back(acc[7:0]);
    return q;
  endfunction

  task automatic feed(input byte_q_t q, input int tick_pct);
    foreach (q[i]) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        repeat ($urandom_range(1, 3)) tick();
      end
      put_byte(q[i]);
    end
  endtask

  // One reply: mostly well formed, sometimes with an exception bit or a bad unit, function, CRC or length.
  task automatic send_frame(input bit force_long);
    byte_q_t    q;
    logic [7:0] ua;
    logic [7:0] fb;
    logic [7:0] cnt;
    logic [6:0] fc;
    logic [8:0] fl;
    int         total;
    int         r;
    int         idx;
    bit         big;
    ua = 8'($urandom);
    fc = 7'($urandom);
    big = force_long || ($urandom_range(0, 99) < 3);
    fb = {1'b0, fc};
    r = $urandom_range(0, 99);
    if (r < 10) begin
      fb[7] = 1'b1;
    end else if (r < 18) begin
      fb[6:0] = fc ^ 7'($urandom_range(1, 127));
    end
    q.push_back(($urandom_range(0, 99) < 8) ? ua ^ 8'($urandom_range(1, 255)) : ua);
    q.push_back(fb);
    if ($urandom_range(0, 1) == 1) begin
      fl = 9'd0;
      cnt = big ? 8'($urandom_range(246, 255)) : 8'($urandom_range(0, 12));
      q.push_back(cnt);
      total = int'(cnt) + 5;
    end else begin
      fl = big ? 9'($urandom_range(200, 256)) : 9'($urandom_range(1, 16));
      total = (fl < 4) ? 4 : int'(fl);
    end
    while (q.size() < total - 2) q.push_back(8'($urandom));
    q = with_crc(q);
    if ($urandom_range(0, 99) < 12) begin
      idx = $urandom_range(0, q.size() - 1);
      q[idx] = q[idx] ^ 8'(1 << $urandom_range(0, 7));
    end
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(1, 3)) void'(q.pop_back());
    end
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
    end
    arm(ua, fc, fl);
    if (cur_limit < 200 && $urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(0, cur_limit + 1)) tick();
    end
    feed(q, 8);
  endtask

  task automatic run_phase(input logic [15:0] lim, input int n_items, input bit squeeze);
    int stop_at;
    write_timeout(lim);
    stop_at = sent + n_items;
    if (squeeze) begin
      hold_requests++;
    end
    while (sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 80) begin
        send_frame(1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 7'($urandom),
                    9'($urandom_range(0, 256)));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    byte_q_t q;
    in_ch.valid <= 1'b0;
    in_ch.func <= mbrc_pkg::FUNC_ARM;
    in_ch.rx_byte <= 8'h00;
    in_ch.unit_address <= 8'h00;
    in_ch.function_code <= 7'h00;
    in_ch.fixed_length <= 9'd0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.timeout_ticks <= 16'h0000;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Items with no reply pending are ignored, as is the unused item kind.
    put_byte(8'h5A);
    tick();
    send_item(FUNC_UNUSED, 8'hFF, 8'hFF, 7'h7F, 9'd256);

    // Exception bit with a fixed length of 4 still ends in a CRC verdict; a second arm is busy.
    arm(8'hFF, 7'h7F, 9'd4);
    arm(8'h00, 7'h00, 9'd0);
    q = {8'hFF, 8'hFF};
    feed(with_crc(q), 0);

    // A fixed length of 1 is taken as 4; zero CRC bytes do not match.
    arm(8'h00, 7'h00, 9'd1);
    q = {8'h00, 8'h00, 8'h00, 8'h00};
    feed(q, 0);

    // Exception reply, reported at the fifth byte with the third byte as its code.
    arm(8'h11, 7'h03, 9'd0);
    q = {8'h11, 8'h83, 8'hFF, 8'h00, 8'h00};
    feed(q, 0);

    // Length from the byte count, empty payload.
    arm(8'hA5, 7'h10, 9'd0);
    q = {8'hA5, 8'h10, 8'h00};
    feed(with_crc(q), 0);

    arm(8'h01, 7'h01, 9'd0);
    q = {8'h02, 8'h01};
    feed(q, 0);
    arm(8'h01, 7'h01, 9'd0);
    q = {8'h01, 8'h02};
    feed(q, 0);

    // A limit of zero times out on the first tick.
    write_timeout(16'd0);
    arm(8'h33, 7'h04, 9'd8);
    tick();
    write_timeout(16'd3);
    arm(8'h33, 7'h04, 9'd8);
    repeat (4) tick();

    // Long replies: byte counts near the buffer size, some of them overflow it.
    write_timeout(mbrc_pkg::TIMEOUT_RESET);
    repeat (2) send_frame(1'b1);

    run_phase(16'd0, 200, 1'b0);
    run_phase(16'($urandom_range(4, 40)), 450, 1'b1);
    run_phase(16'($urandom_range(300, 60000)), 250, 1'b0);
    run_phase(16'hFFFF, 200, 1'b0);

    // With the largest limit a reply does not time out, however many ticks arrive.
    idle_on = 1'b0;
    arm(8'h2C, 7'h03, 9'd4);
    repeat (40) tick();
    q = {8'h2C, 8'h03};
    feed(with_crc(q), 0);
    repeat (5) send_frame(1'b0);

    drain();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
